@@ hw/rtl/wrie_pkg.sv @@
// Shared types, constants and helpers of the wildcard row index expansion block.
`default_nettype none
package wrie_pkg;

	localparam int NUM_COLS     = 3;
	localparam int MAX_COLUMNS  = 3;
	localparam int MAX_SCALE    = 4;
	localparam int MAP_DEPTH    = 64;
	localparam int RESULT_CAP   = 64;
	localparam int IDX_W        = $clog2(MAP_DEPTH);
	localparam int CNT_W        = $clog2(RESULT_CAP);
	localparam int VAL_W        = $clog2(MAX_SCALE);
	localparam int SC_W         = $clog2(MAX_SCALE + 1);
	localparam int FIELD_VAL_W  = 2;
	localparam int CFG_COUNT_W  = 2;
	localparam int CFG_SCALE_W  = 3;
	localparam int CFG_DATA_W   = 3;
	localparam int CFG_INDEX_W  = 2;

	typedef enum logic [CFG_INDEX_W-1:0] {
		CFG_COLUMN_COUNT = 2'd0,
		CFG_SCALE_COL0   = 2'd1,
		CFG_SCALE_COL1   = 2'd2,
		CFG_SCALE_COL2   = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	// Controls broadcast to every cell of the chain.
	typedef struct packed {
		logic load;
		logic step;
	} cell_ctrl_t;

	// One column of a row together with its configured scale.
	typedef struct packed {
		logic                   in_use;
		logic                   any;
		logic [FIELD_VAL_W-1:0] value;
		logic [CFG_SCALE_W-1:0] scale;
	} col_in_t;

	// Map a raw scale register onto 1..MAX_SCALE.
	function automatic logic [SC_W-1:0] clamp_scale(input logic [CFG_SCALE_W-1:0] s);
		logic [SC_W-1:0] r;
		if (s == '0) begin
			r = SC_W'(1);
		end else if (32'(s) > MAX_SCALE) begin
			r = SC_W'(MAX_SCALE);
		end else begin
			r = SC_W'(s);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

@@ hw/rtl/wrie_cell.sv @@
// One odometer digit: holds a column's value, scale and weight, passes carry and sum.
`default_nettype none
module wrie_cell (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  wrie_pkg::cell_ctrl_t   ctrl,
	input  wire  wrie_pkg::col_in_t      col,
	input  wire  [wrie_pkg::IDX_W-1:0]   weight_in,
	output logic [wrie_pkg::IDX_W-1:0]   weight_out,
	input  wire                          carry_in,
	output logic                         carry_out,
	input  wire  [wrie_pkg::IDX_W-1:0]   sum_in,
	output logic [wrie_pkg::IDX_W-1:0]   sum_out
);

	logic                          in_use_q;
	logic                          any_q;
	logic [wrie_pkg::VAL_W-1:0]    val_q;
	logic [wrie_pkg::SC_W-1:0]     scale_q;
	logic [wrie_pkg::IDX_W-1:0]    weight_q;

	logic [wrie_pkg::SC_W-1:0]     scale_ld;
	logic [wrie_pkg::SC_W-1:0]     top_ld;
	logic [wrie_pkg::VAL_W-1:0]    val_ld;
	logic [wrie_pkg::SC_W-1:0]     val_inc;
	logic                          wrap;
	logic [wrie_pkg::IDX_W-1:0]    prod;

	// Load-time values from the raw column and scale.
	always_comb begin
		scale_ld = wrie_pkg::clamp_scale(col.scale);
		top_ld   = scale_ld - wrie_pkg::SC_W'(1);
		if (8'(col.value) > 8'(top_ld)) begin
			val_ld = wrie_pkg::VAL_W'(top_ld);
		end else begin
			val_ld = wrie_pkg::VAL_W'(col.value);
		end
		if (col.any) begin
			val_ld = '0;
		end
		weight_out = col.in_use ? wrie_pkg::IDX_W'(weight_in * wrie_pkg::IDX_W'(scale_ld))
		                        : weight_in;
	end

	// Odometer step and index contribution.
	always_comb begin
		val_inc   = wrie_pkg::SC_W'(val_q) + wrie_pkg::SC_W'(1);
		wrap      = (val_inc >= scale_q);
		carry_out = (in_use_q && any_q) ? (carry_in && wrap) : carry_in;
		prod      = wrie_pkg::IDX_W'(weight_q * wrie_pkg::IDX_W'(val_q));
		sum_out   = in_use_q ? (sum_in + prod) : sum_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= 1'b0;
			any_q    <= 1'b0;
		end else if (ctrl.load) begin
			in_use_q <= col.in_use;
			any_q    <= col.any;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			val_q    <= val_ld;
			scale_q  <= scale_ld;
			weight_q <= weight_in;
		end else if (ctrl.step && in_use_q && any_q && carry_in) begin
			val_q <= wrap ? '0 : wrie_pkg::VAL_W'(val_inc);
		end
	end

endmodule
`default_nettype wire

@@ hw/rtl/wrie_chain.sv @@
// Row of odometer cells: weight and carry run right to left, index sum left to right.
`default_nettype none
module wrie_chain (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire  wrie_pkg::cell_ctrl_t   ctrl,
	input  wire  wrie_pkg::col_in_t      cols [wrie_pkg::NUM_COLS],
	output logic [wrie_pkg::IDX_W-1:0]   index,
	output logic                         wrap
);

	logic [wrie_pkg::IDX_W-1:0] weight_w [wrie_pkg::NUM_COLS+1];
	logic                       carry_w  [wrie_pkg::NUM_COLS+1];
	logic [wrie_pkg::IDX_W-1:0] sum_w    [wrie_pkg::NUM_COLS+1];

	assign weight_w[wrie_pkg::NUM_COLS] = wrie_pkg::IDX_W'(1);
	assign carry_w[wrie_pkg::NUM_COLS]  = 1'b1;
	assign sum_w[0]                     = '0;

	for (genvar c = 0; c < wrie_pkg::NUM_COLS; c++) begin : g_cell
		wrie_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.col        (cols[c]),
			.weight_in  (weight_w[c+1]),
			.weight_out (weight_w[c]),
			.carry_in   (carry_w[c+1]),
			.carry_out  (carry_w[c]),
			.sum_in     (sum_w[c]),
			.sum_out    (sum_w[c+1])
		);
	end

	assign index = sum_w[wrie_pkg::NUM_COLS];
	assign wrap  = carry_w[0];

endmodule
`default_nettype wire

@@ hw/rtl/wildcard_row_index_expansion_core.sv @@
// Top level of the wildcard row index expansion block.
//
//  channel  signals                                         direction
//  -------  ----------------------------------------------  ---------
//  input    in_valid/in_stall, colK_value, colK_any, restart  in (stall out)
//  output   out_valid/out_stall, row_index, first_seen, last  out (stall in)
//  config   cfg_valid/cfg_ready, cfg_index, cfg_data          in (ready out)
//
// A row is loaded, then one combination is emitted per cycle while the
// output register is free, up to the product of the wildcard scales (at
// most 64), paced by the single output register and the odometer chain.
// The output register holds while out_stall is high and the chain holds
// with it. Reset clears the seen map at once (64 flops) and the config
// registers to column_count 3 and scales 4. A restart request clears the
// map in its load cycle.
`default_nettype none
module wildcard_row_index_expansion_core (
	input  wire                                clk,
	input  wire                                arst_n,
	// input request channel
	input  wire                                in_valid,
	output logic                               in_stall,
	input  wire  [wrie_pkg::FIELD_VAL_W-1:0]   col0_value,
	input  wire                                col0_any,
	input  wire  [wrie_pkg::FIELD_VAL_W-1:0]   col1_value,
	input  wire                                col1_any,
	input  wire  [wrie_pkg::FIELD_VAL_W-1:0]   col2_value,
	input  wire                                col2_any,
	input  wire                                restart,
	// result channel
	output logic                               out_valid,
	input  wire                                out_stall,
	output logic [wrie_pkg::IDX_W-1:0]         row_index,
	output logic                               first_seen,
	output logic                               last,
	// configuration write channel
	input  wire                                cfg_valid,
	output logic                               cfg_ready,
	input  wire  [wrie_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire  [wrie_pkg::CFG_DATA_W-1:0]    cfg_data
);

	// Configuration registers.
	logic [wrie_pkg::CFG_COUNT_W-1:0] column_count_q;
	logic [wrie_pkg::CFG_SCALE_W-1:0] scale_col0_q;
	logic [wrie_pkg::CFG_SCALE_W-1:0] scale_col1_q;
	logic [wrie_pkg::CFG_SCALE_W-1:0] scale_col2_q;

	// Control and output state.
	wrie_pkg::state_t               state_q, state_d;
	logic [wrie_pkg::CNT_W-1:0]     count_q;
	logic [wrie_pkg::MAP_DEPTH-1:0] seen_q;
	logic                           out_valid_q;
	logic [wrie_pkg::IDX_W-1:0]     row_index_q;
	logic                           first_seen_q;
	logic                           last_q;

	wrie_pkg::cell_ctrl_t           ctrl;
	wrie_pkg::col_in_t              cols [wrie_pkg::NUM_COLS];
	logic [wrie_pkg::CFG_COUNT_W-1:0] ncols;
	logic [wrie_pkg::IDX_W-1:0]     index;
	logic                           wrap;
	logic                           emit;
	logic                           done;
	logic                           load;

	// Config writes must be issued only while idle; the block does not enforce it and always takes them.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= wrie_pkg::CFG_COUNT_W'(3);
			scale_col0_q   <= wrie_pkg::CFG_SCALE_W'(4);
			scale_col1_q   <= wrie_pkg::CFG_SCALE_W'(4);
			scale_col2_q   <= wrie_pkg::CFG_SCALE_W'(4);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				wrie_pkg::CFG_COLUMN_COUNT: begin
					column_count_q <= cfg_data[wrie_pkg::CFG_COUNT_W-1:0];
				end
				wrie_pkg::CFG_SCALE_COL0: begin
					scale_col0_q <= cfg_data;
				end
				wrie_pkg::CFG_SCALE_COL1: begin
					scale_col1_q <= cfg_data;
				end
				wrie_pkg::CFG_SCALE_COL2: begin
					scale_col2_q <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	// Effective column count: zero acts as one, saturate at MAX_COLUMNS.
	always_comb begin
		ncols = column_count_q;
		if (ncols == '0) begin
			ncols = wrie_pkg::CFG_COUNT_W'(1);
		end
		if (32'(ncols) > wrie_pkg::MAX_COLUMNS) begin
			ncols = wrie_pkg::CFG_COUNT_W'(wrie_pkg::MAX_COLUMNS);
		end
	end

	// Present the row to the chain; columns past the count are ignored.
	always_comb begin
		cols[0] = '{in_use: 1'b1, any: col0_any, value: col0_value, scale: scale_col0_q};
		cols[1] = '{in_use: 1'b1, any: col1_any, value: col1_value, scale: scale_col1_q};
		cols[2] = '{in_use: 1'b1, any: col2_any, value: col2_value, scale: scale_col2_q};
		for (int c = 0; c < wrie_pkg::NUM_COLS; c++) begin
			cols[c].in_use = (c < int'(ncols));
		end
	end

	wrie_chain u_chain (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.cols   (cols),
		.index  (index),
		.wrap   (wrap)
	);

	// Last combination: odometer rolled over, or result cap reached.
	assign done = wrap || (count_q == wrie_pkg::CNT_W'(wrie_pkg::RESULT_CAP - 1));

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wrie_pkg::ST_IDLE: begin
				if (in_valid) begin
					state_d = wrie_pkg::ST_RUN;
				end
			end
			wrie_pkg::ST_RUN: begin
				if (emit && done) begin
					state_d = wrie_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wrie_pkg::ST_IDLE;
			end
		endcase
	end

	// Outputs of the sequencer.
	always_comb begin
		in_stall  = 1'b1;
		emit      = 1'b0;
		unique case (state_q)
			wrie_pkg::ST_IDLE: begin
				in_stall = 1'b0;
			end
			wrie_pkg::ST_RUN: begin
				emit = !out_valid_q || !out_stall;
			end
			default: begin
			end
		endcase
		load      = in_valid && !in_stall;
		ctrl.load = load;
		ctrl.step = emit;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= wrie_pkg::ST_IDLE;
			count_q     <= '0;
			seen_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Restart clears the map before the row expands.
			if (load) begin
				count_q <= '0;
				if (restart) begin
					seen_q <= '0;
				end
			end else if (emit) begin
				count_q       <= count_q + wrie_pkg::CNT_W'(1);
				seen_q[index] <= 1'b1;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Result payload; advance only when a new combination is emitted.
	always_ff @(posedge clk) begin
		if (emit) begin
			row_index_q  <= index;
			first_seen_q <= !seen_q[index];
			last_q       <= done;
		end
	end

	assign out_valid  = out_valid_q;
	assign row_index  = row_index_q;
	assign first_seen = first_seen_q;
	assign last       = last_q;

endmodule
`default_nettype wire

@@ tb/sv/tb_wildcard_row_index_expansion_core.sv @@
// Testbench for the wildcard row index expansion core: self-checking stimulus and prediction.
`timescale 1ns / 100ps

module tb_wildcard_row_index_expansion_core;
	import wrie_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;  // cycles with no handshake on any channel
	localparam int SETTLE_CYCLES  = 70;    // long enough for one full row of 64 indices and its load
	localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
	localparam int IDLE_PCT       = 16;

	// One input request: per-column fixed value and wildcard flag, plus restart.
	typedef struct packed {
		logic                              restart;
		logic [NUM_COLS-1:0]               any;
		logic [NUM_COLS-1:0][FIELD_VAL_W-1:0] value;
	} row_t;

	// One expanded combination as the block reports it.
	typedef struct packed {
		logic [IDX_W-1:0] row_index;
		logic             first_seen;
		logic             last;
	} index_t;

	logic                   clk;
	logic                   arst_n;
	logic                   in_valid;
	logic                   in_stall;
	logic [FIELD_VAL_W-1:0] col0_value;
	logic                   col0_any;
	logic [FIELD_VAL_W-1:0] col1_value;
	logic                   col1_any;
	logic [FIELD_VAL_W-1:0] col2_value;
	logic                   col2_any;
	logic                   restart;
	logic                   out_valid;
	logic                   out_stall;
	logic [IDX_W-1:0]       row_index;
	logic                   first_seen;
	logic                   last;
	logic                   cfg_valid;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0]  cfg_data;

	// Predictor copy of the registers and the seen map.
	logic [CFG_COUNT_W-1:0] col_count_q;
	logic [CFG_SCALE_W-1:0] scale_q [NUM_COLS];
	logic [MAP_DEPTH-1:0]   seen_q;

	index_t index_queue[$];     // expanded indices still owed by the block
	int     mismatch_count;
	int     idle_count;
	int     hold_left;          // receiver hold-off, counted down by the receiver
	bit     quiet;              // suppress random idling on both sides

	wildcard_row_index_expansion_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.col0_value (col0_value),
		.col0_any   (col0_any),
		.col1_value (col1_value),
		.col1_any   (col1_any),
		.col2_value (col2_value),
		.col2_any   (col2_any),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.row_index  (row_index),
		.first_seen (first_seen),
		.last       (last),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Expand one accepted row into the indices it must produce, in odometer order.
	task automatic expand_row(input row_t r);
		int     n;
		int     c;
		int     k;
		int     j;
		int     idx;
		int     addr;
		int     count;
		int     sc [NUM_COLS];
		int     wt [NUM_COLS];
		int     v  [NUM_COLS];
		bit     carry;
		bit     done;
		index_t e;
		n = (col_count_q == 0) ? 1 : int'(col_count_q);
		if (n > MAX_COLUMNS)
			n = MAX_COLUMNS;
		for (c = 0; c < NUM_COLS; c++) begin
			// zero scale counts as one, oversize scales saturate
			if (scale_q[c] == 0)
				sc[c] = 1;
			else if (int'(scale_q[c]) > MAX_SCALE)
				sc[c] = MAX_SCALE;
			else
				sc[c] = int'(scale_q[c]);
			// wildcards start at zero, fixed values saturate to scale minus one
			if (r.any[c])
				v[c] = 0;
			else if (int'(r.value[c]) > sc[c] - 1)
				v[c] = sc[c] - 1;
			else
				v[c] = int'(r.value[c]);
		end
		// last column in use has unit weight
		wt[n-1] = 1;
		for (c = n - 1; c > 0; c--)
			wt[c-1] = wt[c] * sc[c];
		if (r.restart)
			seen_q = '0;
		count = 0;
		done  = 1'b0;
		while (!done) begin
			idx = 0;
			for (c = 0; c < n; c++)
				idx += wt[c] * v[c];
			addr = idx % MAP_DEPTH;
			// advance the odometer, rightmost wildcard fastest
			carry = 1'b1;
			for (k = n; k > 0 && carry; k--) begin
				j = k - 1;
				if (r.any[j]) begin
					v[j]++;
					if (v[j] >= sc[j])
						v[j] = 0;
					else
						carry = 1'b0;
				end
			end
			done         = carry || (count + 1 >= RESULT_CAP);
			e.row_index  = IDX_W'(addr);
			e.first_seen = !seen_q[addr];
			e.last       = done;
			seen_q[addr] = 1'b1;
			index_queue.push_back(e);
			count++;
		end
	endtask

	function automatic row_t row_of(input bit rst, input bit [NUM_COLS-1:0] any_mask,
			input bit [FIELD_VAL_W-1:0] v0, input bit [FIELD_VAL_W-1:0] v1,
			input bit [FIELD_VAL_W-1:0] v2);
		row_t r;
		r.restart  = rst;
		r.any      = any_mask;
		r.value[0] = v0;
		r.value[1] = v1;
		r.value[2] = v2;
		return r;
	endfunction

	// Mostly fixed columns with some wildcards; restart now and then.
	function automatic row_t rand_row();
		row_t r;
		int   c;
		for (c = 0; c < NUM_COLS; c++) begin
			r.any[c]   = ($urandom_range(99) < 30);
			r.value[c] = FIELD_VAL_W'($urandom);
		end
		r.restart = ($urandom_range(7) == 0);
		return r;
	endfunction

	// Offer one row, hold it until accepted, then predict it. Valid stays high on return.
	task automatic send_row(input row_t r);
		while (!quiet && $urandom_range(99) < IDLE_PCT) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid   <= 1'b1;
		col0_value <= r.value[0];
		col0_any   <= r.any[0];
		col1_value <= r.value[1];
		col1_any   <= r.any[1];
		col2_value <= r.value[2];
		col2_any   <= r.any[2];
		restart    <= r.restart;
		do
			@(posedge clk);
		while (in_stall);
		expand_row(r);
	endtask

	// Drop valid and wait until every owed index has come out.
	task automatic drain_rows();
		@(negedge clk);
		in_valid <= 1'b0;
		while (index_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do
			@(posedge clk);
		while (!cfg_ready);
		case (idx)
			CFG_COLUMN_COUNT: col_count_q = data[CFG_COUNT_W-1:0];
			CFG_SCALE_COL0:   scale_q[0]  = data;
			CFG_SCALE_COL1:   scale_q[1]  = data;
			CFG_SCALE_COL2:   scale_q[2]  = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Reconfigure only once the block has gone idle.
	task automatic set_config(input logic [CFG_DATA_W-1:0] count,
			input logic [CFG_DATA_W-1:0] s0, input logic [CFG_DATA_W-1:0] s1,
			input logic [CFG_DATA_W-1:0] s2);
		drain_rows();
		write_reg(CFG_COLUMN_COUNT, count);
		write_reg(CFG_SCALE_COL0, s0);
		write_reg(CFG_SCALE_COL1, s1);
		write_reg(CFG_SCALE_COL2, s2);
	endtask

	// Reset configuration, fixed columns only: extremes and a repeated index.
	task automatic test_fixed_rows();
		send_row(row_of(1'b1, 3'b000, 2'd0, 2'd0, 2'd0));
		send_row(row_of(1'b0, 3'b000, 2'd3, 2'd3, 2'd3));
		send_row(row_of(1'b0, 3'b000, 2'd3, 2'd3, 2'd3));
		send_row(row_of(1'b0, 3'b000, 2'd2, 2'd1, 2'd0));
	endtask

	// Wildcards in each position, then the full 64-index sweep with and without restart.
	task automatic test_wildcards();
		send_row(row_of(1'b0, 3'b100, 2'd1, 2'd2, 2'd3));
		send_row(row_of(1'b0, 3'b001, 2'd3, 2'd0, 2'd1));
		send_row(row_of(1'b0, 3'b010, 2'd0, 2'd3, 2'd2));
		send_row(row_of(1'b0, 3'b101, 2'd2, 2'd2, 2'd2));
		send_row(row_of(1'b1, 3'b111, 2'd3, 2'd3, 2'd3));
		send_row(row_of(1'b0, 3'b111, 2'd0, 2'd1, 2'd2));
	endtask

	// Register extremes: zero count, zero and oversize scales, unused columns, scale one.
	task automatic test_config_extremes();
		set_config(3'd0, 3'd7, 3'd0, 3'd0);
		send_row(row_of(1'b0, 3'b110, 2'd3, 2'd1, 2'd2));
		send_row(row_of(1'b1, 3'b111, 2'd1, 2'd3, 2'd3));
		set_config(3'd2, 3'd0, 3'd2, 3'd5);
		send_row(row_of(1'b0, 3'b000, 2'd3, 2'd3, 2'd3));
		send_row(row_of(1'b0, 3'b111, 2'd0, 2'd0, 2'd0));
		set_config(3'd7, 3'd1, 3'd1, 3'd1);
		send_row(row_of(1'b1, 3'b111, 2'd3, 2'd3, 2'd3));
		send_row(row_of(1'b0, 3'b000, 2'd3, 2'd2, 2'd1));
		set_config(3'd3, 3'd6, 3'd3, 3'd4);
		send_row(row_of(1'b1, 3'b111, 2'd1, 2'd1, 2'd1));
	endtask

	// Hold the receiver off while rows keep coming, pause until all is out, then send eight more rows.
	task automatic test_backpressure();
		set_config(3'd3, 3'd4, 3'd4, 3'd4);
		hold_left = HOLD_CYCLES;
		repeat (16)
			send_row(rand_row());
		drain_rows();
		repeat (8)
			send_row(rand_row());
	endtask

	// Random configurations, each followed by a batch of random rows.
	task automatic test_random();
		int phase;
		for (phase = 0; phase < 8; phase++) begin
			set_config(CFG_DATA_W'($urandom_range(7)), CFG_DATA_W'($urandom_range(7)),
				CFG_DATA_W'($urandom_range(7)), CFG_DATA_W'($urandom_range(7)));
			// run two phases back to back with no idling at all
			quiet = (phase == 3 || phase == 4);
			repeat (50)
				send_row(rand_row());
		end
		quiet = 1'b0;
	endtask

	initial begin
		clk            = 1'b0;
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		col0_value     = '0;
		col0_any       = 1'b0;
		col1_value     = '0;
		col1_any       = 1'b0;
		col2_value     = '0;
		col2_any       = 1'b0;
		restart        = 1'b0;
		out_stall      = 1'b0;
		cfg_valid      = 1'b0;
		cfg_index      = CFG_COLUMN_COUNT;
		cfg_data       = '0;
		col_count_q    = CFG_COUNT_W'(3);
		scale_q[0]     = CFG_SCALE_W'(4);
		scale_q[1]     = CFG_SCALE_W'(4);
		scale_q[2]     = CFG_SCALE_W'(4);
		seen_q         = '0;
		mismatch_count = 0;
		idle_count     = 0;
		hold_left      = 0;
		quiet          = 1'b0;
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_fixed_rows();
		test_wildcards();
		test_config_extremes();
		test_backpressure();
		test_random();

		// wait out the owed indices, then watch for strays
		drain_rows();
		repeat (SETTLE_CYCLES)
			@(posedge clk);
		if (mismatch_count == 0 && index_queue.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	// Receiver: honor a requested hold-off, otherwise stall at random.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left = hold_left - 1;
		end else begin
			out_stall <= !quiet && ($urandom_range(99) < IDLE_PCT);
		end
	end

	// Compare each accepted result with the oldest owed index.
	always @(posedge clk) begin : check_results
		index_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (index_queue.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result: row_index %0d first_seen %0b last %0b",
						row_index, first_seen, last);
			end else begin
				want = index_queue.pop_front();
				if (row_index !== want.row_index || first_seen !== want.first_seen ||
						last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("result mismatch: expected idx %0d first %0b last %0b, got idx %0d first %0b last %0b",
							want.row_index, want.first_seen, want.last,
							row_index, first_seen, last);
				end
			end
		end
	end

	// Watchdog: end the run if no channel moves for too long.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_count = 0;
		else
			idle_count = idle_count + 1;
		if (idle_count >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

endmodule
